FILE: rtl/core/nch_pkg.sv
// Shared constants for the nearest centroid histogram block.
package nch_pkg;
	localparam int MaxCentroids = 64;
	localparam int MaxLength = 128;
	localparam int CountBits = 24;

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_DESC = 2'd1;
	localparam logic [1:0] MODE_FINISH = 2'd2;

	localparam logic CFG_NUM_CENTROIDS = 1'b0;
	localparam logic CFG_VECTOR_LENGTH = 1'b1;

	localparam logic KIND_ASSIGN = 1'b0;
	localparam logic KIND_BIN = 1'b1;
endpackage

FILE: rtl/core/nch_divider.sv
// Restoring divider: floor((count << 16) / total), one quotient bit per cycle.
module nch_divider import nch_pkg::*; #(
	parameter int COUNT_BITS = CountBits
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [COUNT_BITS-1:0] count,
	input  logic [COUNT_BITS-1:0] total,
	output logic                  done,
	output logic [16:0]           quot
);
	localparam int NB = COUNT_BITS + 16;
	localparam int CW = $clog2(NB + 1);

	logic [NB-1:0]     num_q;
	logic [COUNT_BITS:0] rem_q;
	logic [COUNT_BITS-1:0] den_q;
	logic [NB-1:0]     quo_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q, done_q;
	logic [COUNT_BITS+1:0] trial;
	logic [COUNT_BITS:0] shifted;

	assign shifted = {rem_q[COUNT_BITS-1:0], num_q[NB-1]};
	assign trial = {1'b0, shifted} - {2'b00, den_q};

	// shift one numerator bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {count, 16'd0};
			rem_q <= '0;
			den_q <= total;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NB-2:0], 1'b0};
			if (!trial[COUNT_BITS+1]) begin
				rem_q <= trial[COUNT_BITS:0];
				quo_q <= {quo_q[NB-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NB-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	// count <= total, so the quotient fits in 17 bits
	assign quot = (den_q == '0) ? 17'd0 : quo_q[16:0];
endmodule

FILE: rtl/core/nearest_centroid_histogram.sv
// Top level: centroid store, descriptor buffer, distance sequencer, histogram.
//
//  channel | signals                                        | direction
//  in      | in_valid in_ready mode centroid_index ...      | input items
//  out     | out_valid out_ready kind bin_index ...         | result items
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data         | register writes
//
// Load items and non-final descriptor elements are taken whenever the block is idle.
// A final descriptor element starts the distance pass: one shared
// subtract-square-accumulate unit walks the store one element per cycle.
// A finish item runs each bin count through the serial divider in turn.
// Reset clears counts and control; the stores are left unwritten.
// A stalled result holds the sequencer at its next result; while idle,
// load and element items are still taken.
module nearest_centroid_histogram import nch_pkg::*; #(
	parameter int MAX_CENTROIDS = MaxCentroids,
	parameter int MAX_LENGTH = MaxLength,
	parameter int COUNT_BITS = CountBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [5:0]  centroid_index,
	input  logic [6:0]  element_index,
	input  logic [15:0] element_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [5:0]  bin_index,
	output logic [16:0] bin_fraction,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	localparam int CB = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
	localparam int LB = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int KW = $clog2(MAX_CENTROIDS + 1);
	localparam int NW = $clog2(MAX_LENGTH + 1);
	localparam int DEPTH = MAX_CENTROIDS * MAX_LENGTH;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIST = 3'd1;
	localparam logic [2:0] ST_CMP  = 3'd2;
	localparam logic [2:0] ST_AOUT = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_DWT  = 3'd5;
	localparam logic [2:0] ST_BOUT = 3'd6;
	localparam logic [2:0] ST_ARD  = 3'd7;

	logic [2:0] state_q;
	logic [6:0] numc_q;
	logic [7:0] vlen_q;
	logic [KW-1:0] k_eff;
	logic [NW-1:0] n_eff;

	logic [15:0] cstore [DEPTH];
	logic [15:0] dbuf [MAX_LENGTH];
	logic [COUNT_BITS-1:0] bins_mem [MAX_CENTROIDS];
	logic [MAX_CENTROIDS-1:0] bin_vld_q;
	logic [COUNT_BITS-1:0] bin_rd_q, bin_cur;
	logic          bin_hit_q;
	logic [CB-1:0] bin_raddr;
	logic          bin_we;
	logic [COUNT_BITS-1:0] total_q;

	logic [CB-1:0] c_q, best_q;
	logic [LB-1:0] e_q;
	logic          rd_v_s1, rd_v_s2, rd_v_s3, rd_last_s1, rd_last_s2, rd_last_s3;
	logic [15:0]   cval_s1, dval_s1;
	logic [16:0]   diff_s2;
	logic [63:0]   acc_q, best_d_q;
	logic          first_q;
	logic [16:0]   frac_q;
	logic          last_q, kind_q;
	logic [5:0]    bidx_q;
	logic          ov_q;
	logic          div_start;
	logic          div_done;
	logic [16:0]   dquot;

	// clamp the registers into range
	always_comb begin
		if (numc_q == '0) k_eff = KW'(1);
		else if (32'(numc_q) > MAX_CENTROIDS) k_eff = KW'(MAX_CENTROIDS);
		else k_eff = KW'(numc_q);
		if (vlen_q == '0) n_eff = NW'(1);
		else if (32'(vlen_q) > MAX_LENGTH) n_eff = NW'(MAX_LENGTH);
		else n_eff = NW'(vlen_q);
	end

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE);
	logic acc_in;
	assign acc_in = in_valid && in_ready;
	logic desc_end;
	assign desc_end = (mode == MODE_DESC) && (32'(element_index) == 32'(n_eff) - 1);

	// write the stores
	always_ff @(posedge clk) begin
		if (acc_in && mode == MODE_LOAD && 32'(centroid_index) < MAX_CENTROIDS
		    && 32'(element_index) < MAX_LENGTH)
			cstore[AW'(32'(centroid_index) * MAX_LENGTH + 32'(element_index))] <= element_value;
		if (acc_in && mode == MODE_DESC && 32'(element_index) < MAX_LENGTH)
			dbuf[LB'(element_index)] <= element_value;
	end

	// read both stores for the current element
	always_ff @(posedge clk) begin
		cval_s1 <= cstore[AW'(32'(c_q) * MAX_LENGTH + 32'(e_q))];
		dval_s1 <= dbuf[e_q];
		diff_s2 <= (cval_s1 > dval_s1) ? {1'b0, cval_s1 - dval_s1}
		                               : {1'b0, dval_s1 - cval_s1};
	end

	// a bin never written since the last clear reads as zero
	assign bin_raddr = (state_q == ST_ARD || state_q == ST_AOUT) ? best_q : c_q;
	assign bin_cur = bin_hit_q ? bin_rd_q : '0;
	assign bin_we = (state_q == ST_AOUT) && !ov_q && (bin_cur != CMAX);

	// update and read the bin counts
	always_ff @(posedge clk) begin
		if (bin_we) bins_mem[best_q] <= bin_cur + 1'b1;
		bin_rd_q <= bins_mem[bin_raddr];
	end

	logic [31:0] sq;
	assign sq = diff_s2[15:0] * diff_s2[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			numc_q <= 7'd64;
			vlen_q <= 8'd128;
			total_q <= '0;
			bin_vld_q <= '0;
			bin_hit_q <= 1'b0;
			c_q <= '0; e_q <= '0; best_q <= '0;
			rd_v_s1 <= 1'b0; rd_v_s2 <= 1'b0; rd_v_s3 <= 1'b0;
			rd_last_s1 <= 1'b0; rd_last_s2 <= 1'b0; rd_last_s3 <= 1'b0;
			acc_q <= '0; best_d_q <= '0; first_q <= 1'b0;
			ov_q <= 1'b0; kind_q <= 1'b0; bidx_q <= '0; frac_q <= '0; last_q <= 1'b0;
			div_start <= 1'b0;
		end else begin
			div_start <= 1'b0;
			bin_hit_q <= bin_vld_q[bin_raddr];
			if (cfg_valid) begin
				if (cfg_index == CFG_NUM_CENTROIDS) numc_q <= cfg_data[6:0];
				else numc_q <= numc_q;
				if (cfg_index == CFG_VECTOR_LENGTH) vlen_q <= cfg_data;
			end
			if (ov_q && out_ready) ov_q <= 1'b0;
			// issue pipeline tracking
			rd_v_s3 <= rd_v_s2;
			rd_last_s3 <= rd_last_s2;
			rd_v_s2 <= rd_v_s1;
			rd_last_s2 <= rd_last_s1;
			rd_v_s1 <= 1'b0;
			rd_last_s1 <= 1'b0;
			if (rd_v_s3) acc_q <= acc_q + 64'(sq);
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in && desc_end) begin
						state_q <= ST_DIST;
						c_q <= '0; e_q <= '0; acc_q <= '0; first_q <= 1'b1;
						rd_v_s1 <= 1'b1;
						rd_last_s1 <= (n_eff == NW'(1));
					end else if (acc_in && mode == MODE_FINISH) begin
						state_q <= ST_DIV;
						c_q <= '0;
					end
				end
				ST_DIST: begin
					// issue one element per cycle until the last of this centroid
					if (!rd_last_s1 && !rd_last_s2 && !(rd_v_s2 && !rd_v_s1 && e_q != '0)) begin
						if (32'(e_q) + 1 < 32'(n_eff)) begin
							e_q <= e_q + 1'b1;
							rd_v_s1 <= 1'b1;
							rd_last_s1 <= (32'(e_q) + 2 == 32'(n_eff));
						end
					end
					if (rd_last_s3) state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (first_q || acc_q < best_d_q) begin
						best_d_q <= acc_q;
						best_q <= c_q;
					end
					first_q <= 1'b0;
					if (32'(c_q) + 1 < 32'(k_eff)) begin
						c_q <= c_q + 1'b1;
						e_q <= '0;
						acc_q <= '0;
						rd_v_s1 <= 1'b1;
						rd_last_s1 <= (n_eff == NW'(1));
						state_q <= ST_DIST;
					end else begin
						state_q <= ST_ARD;
					end
				end
				ST_ARD: begin
					// fetch the winning bin's count
					state_q <= ST_AOUT;
				end
				ST_AOUT: begin
					if (!ov_q) begin
						bin_vld_q[best_q] <= 1'b1;
						if (total_q != CMAX) total_q <= total_q + 1'b1;
						ov_q <= 1'b1; kind_q <= KIND_ASSIGN;
						bidx_q <= 6'(best_q); frac_q <= '0; last_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					div_start <= 1'b1;
					state_q <= ST_DWT;
				end
				ST_DWT: begin
					if (div_done) state_q <= ST_BOUT;
				end
				ST_BOUT: begin
					if (!ov_q) begin
						ov_q <= 1'b1; kind_q <= KIND_BIN;
						bidx_q <= 6'(c_q); frac_q <= dquot;
						last_q <= (32'(c_q) + 1 == 32'(k_eff));
						if (32'(c_q) + 1 < 32'(k_eff)) begin
							c_q <= c_q + 1'b1;
							state_q <= ST_DIV;
						end else begin
							bin_vld_q <= '0;
							total_q <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	nch_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.count(bin_cur), .total(total_q), .done(div_done), .quot(dquot)
	);

	assign out_valid = ov_q;
	assign kind = kind_q;
	assign bin_index = bidx_q;
	assign bin_fraction = frac_q;
	assign last = last_q;
endmodule

FILE: rtl/core/nch_checker.sv
// Port-level checks for the nearest centroid histogram block.
module nch_port_checks import nch_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic [16:0] bin_fraction,
	input logic        last
);
	// an assignment carries zero fraction and last
	a_assign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ASSIGN |-> bin_fraction == '0 && last)
		else $error("assignment fields wrong");
	// fraction never exceeds one
	a_frac: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bin_fraction <= 17'h10000)
		else $error("fraction above one");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bin_fraction))
		else $error("result dropped");
	// a new bin result never follows directly on an accepted input
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !($rose(out_valid) && kind == KIND_BIN))
		else $error("bin emitted on plain item");
endmodule

bind nearest_centroid_histogram nch_port_checks u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .kind(kind),
	.bin_fraction(bin_fraction), .last(last)
);
